FILE: rtl/stok_pkg.sv
// Shared types and constants for the script tokenizer.
package stok_pkg;

    // Default token length limit
    localparam int MAX_TOKEN_LEN_DEF = 128;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOT  = 2'd2;

    // Work for the back end from one text byte, emitted in field order:
    // held slash, token byte, token end, end of text.
    typedef struct packed {
        logic       has_slash;
        logic       has_byte;
        logic [7:0] byte_val;
        logic       has_end;
        logic [7:0] len;
        logic       ovf;
        logic       has_eot;
    } stok_entry_t;

endpackage

FILE: rtl/script_tokenizer.sv
// Script tokenizer top level: front scanner, entry queue and result back end.
//
// Text channel (text_valid / text_stall / text_byte) takes one byte per word;
// byte 0 ends the text. Result channel (result_valid / result_stall) gives
// token bytes, token ends with length and overflow flag, and end-of-text
// markers; last marks the final result word caused by one text byte.
// The front accepts one byte every cycle while the queue has room. A byte
// that yields results is pushed as one entry; the back turns an entry into
// one to three words, one per unstalled cycle, into an output register.
// An accepted byte is first written into the queue; its first result word
// is loaded from the queue head into the output register, where the
// receiver takes it. One byte is taken per cycle while bytes yield at most
// one word each and the receiver does not stall; a byte yielding more than
// one word holds the back end until its last word is loaded, and the
// four-entry queue absorbs such bursts before text_stall rises.
// When the receiver stalls, the output word holds, the queue fills and then
// text_stall is raised. Reset empties the queue, drops any pending word and
// puts the scanner between tokens with a zero length count.
module script_tokenizer #(
    parameter int MAX_TOKEN_LEN = stok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] kind,
    output logic [7:0] byte_value,
    output logic [7:0] token_length,
    output logic       overflowed,
    output logic       last
);
    import stok_pkg::*;

    logic        push, pop, full, head_valid;
    stok_entry_t push_entry, head_entry;

    assign text_stall = full;

    stok_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_valid(text_valid),
        .text_byte (text_byte),
        .q_full    (full),
        .push      (push),
        .entry     (push_entry)
    );

    stok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (full),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    stok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind        (kind),
        .byte_value  (byte_value),
        .token_length(token_length),
        .overflowed  (overflowed),
        .last        (last)
    );

endmodule

FILE: rtl/stok_front.sv
// Front end: scan state machine, classifies each text byte into a queue entry.
module stok_front #(
    parameter int MAX_TOKEN_LEN = stok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    input  logic [7:0]          text_byte,
    input  logic                q_full,
    output logic                push,
    output stok_pkg::stok_entry_t entry
);
    import stok_pkg::*;

    localparam int CW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TOKEN_LEN);

    // Scan modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_QUOTE   = 3'd3;
    localparam logic [2:0] MODE_WORD    = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    logic [2:0]    mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          is_word;
    stok_entry_t   e;

    assign accept  = text_valid && !q_full;
    assign is_word = (text_byte > CH_SPACE) && !text_byte[7];

    // Classify the byte against the current mode
    always_comb
    begin
        logic [CW-1:0] base;
        logic          ovf;
        e         = '0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        base      = cnt_reg;
        ovf       = 1'b0;
        unique case (mode_reg) inside
            MODE_SLASH, MODE_WORD:
            begin
                if (mode_reg == MODE_SLASH && text_byte == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    // lone slash opens word; user sets limit >= two, unchecked
                    if (mode_reg == MODE_SLASH)
                    begin
                        e.has_slash = 1'b1;
                        base        = CW'(1);
                    end
                    mode_next = MODE_WORD;
                    cnt_next  = base;
                    if (is_word)
                    begin
                        if (base < MAX_CNT)
                        begin
                            e.has_byte = 1'b1;
                            e.byte_val = text_byte;
                            cnt_next   = base + CW'(1);
                        end
                    end
                    else
                    begin
                        ovf       = (base >= MAX_CNT);
                        e.has_end = 1'b1;
                        e.ovf     = ovf;
                        e.len     = ovf ? 8'd0 : 8'(base);
                        e.has_eot = (text_byte == CH_NUL);
                        cnt_next  = '0;
                        mode_next = MODE_BETWEEN;
                    end
                end
            end
            MODE_COMMENT:
            begin
                if (text_byte == CH_NUL)
                begin
                    e.has_eot = 1'b1;
                    mode_next = MODE_BETWEEN;
                end
                else if (text_byte == CH_NEWLINE)
                begin
                    mode_next = MODE_BETWEEN;
                end
            end
            MODE_QUOTE:
            begin
                if (text_byte == CH_NUL || text_byte == CH_QUOTE)
                begin
                    // closing quote, or end of text closes the string
                    ovf       = (cnt_reg >= MAX_CNT);
                    e.has_end = 1'b1;
                    e.ovf     = ovf;
                    e.len     = ovf ? 8'd0 : 8'(cnt_reg);
                    e.has_eot = (text_byte == CH_NUL);
                    cnt_next  = '0;
                    mode_next = MODE_BETWEEN;
                end
                else if (cnt_reg < MAX_CNT)
                begin
                    e.has_byte = 1'b1;
                    e.byte_val = text_byte;
                    cnt_next   = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                // between tokens; unused codes behave the same
                mode_next = MODE_BETWEEN;
                if (text_byte == CH_NUL)
                begin
                    e.has_eot = 1'b1;
                end
                else if (!is_word)
                begin
                    mode_next = MODE_BETWEEN;
                end
                else if (text_byte == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    mode_next = MODE_QUOTE;
                    cnt_next  = '0;
                end
                else
                begin
                    mode_next  = MODE_WORD;
                    e.has_byte = 1'b1;
                    e.byte_val = text_byte;
                    cnt_next   = CW'(1);
                end
            end
        endcase
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Silent bytes leave nothing in the queue
    assign push  = accept && (e.has_slash || e.has_byte || e.has_end || e.has_eot);
    assign entry = e;

endmodule

FILE: rtl/stok_queue.sv
// Short FIFO of classified entries between front and back.
module stok_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  stok_pkg::stok_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output stok_pkg::stok_entry_t head_entry
);
    import stok_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    stok_entry_t   mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [NW-1:0] count_reg, count_next;

    assign full       = (count_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + NW'(1);
            2'b01:   count_next = count_reg - NW'(1);
            default: count_next = count_reg;
        endcase
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop)
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

endmodule

FILE: rtl/stok_back.sv
// Back end: expands each queue entry into result words behind an output register.
module stok_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  stok_pkg::stok_entry_t head_entry,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [1:0]            kind,
    output logic [7:0]            byte_value,
    output logic [7:0]            token_length,
    output logic                  overflowed,
    output logic                  last
);
    import stok_pkg::*;

    localparam logic [7:0] CH_SLASH = 8'h2F;

    logic [3:0] done_reg, done_next;
    logic [3:0] parts, rem, sel;
    logic       load, final_part;
    logic       valid_reg;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] len_reg, len_next;
    logic       ovf_reg, ovf_next;
    logic       last_reg;

    assign parts = {head_entry.has_eot, head_entry.has_end,
                    head_entry.has_byte, head_entry.has_slash};
    assign rem   = parts & ~done_reg;
    assign load  = head_valid && (!valid_reg || !result_stall);

    // Pick the earliest pending part of the head entry
    always_comb
    begin
        sel       = 4'b0000;
        kind_next = KIND_EOT;
        byte_next = 8'd0;
        len_next  = 8'd0;
        ovf_next  = 1'b0;
        if (rem[0])
        begin
            sel       = 4'b0001;
            kind_next = KIND_BYTE;
            byte_next = CH_SLASH;
        end
        else if (rem[1])
        begin
            sel       = 4'b0010;
            kind_next = KIND_BYTE;
            byte_next = head_entry.byte_val;
        end
        else if (rem[2])
        begin
            sel       = 4'b0100;
            kind_next = KIND_END;
            len_next  = head_entry.len;
            ovf_next  = head_entry.ovf;
        end
        else
        begin
            sel       = 4'b1000;
        end
    end

    assign final_part = ((rem & ~sel) == 4'b0000);
    assign pop        = load && final_part;
    assign done_next  = final_part ? 4'b0000 : (done_reg | sel);

    // Control: progress through the head entry and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 4'b0000;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                done_reg <= done_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!result_stall)
                valid_reg <= 1'b0;
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            last_reg <= final_part;
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign byte_value   = byte_reg;
    assign token_length = len_reg;
    assign overflowed   = ovf_reg;
    assign last         = last_reg;

endmodule
